[hdl/aapb_pkg.sv]
`default_nettype none
package aapb_pkg;

    localparam int DIM_W       = 7;
    localparam int COORD_W     = 6;
    localparam int DATA_W      = 32;
    localparam int MAX_IN_DIM  = 64;
    localparam int MAX_OUT_DIM = 64;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int DEPTH       = MAX_OUT_DIM * MAX_OUT_DIM;
    localparam int DVD_W       = 25;
    localparam int DVS_W       = 13;
    localparam int CNT_W       = 5;
    localparam int MUL_W       = 14;
    localparam int PROD_W      = DATA_W + DVD_W + 1;
    localparam int ACC_W       = 72;
    localparam int SH_W        = ACC_W - 24;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DVD_W-1:0] WEIGHT_ONE = DVD_W'(1) << 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_H  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_W  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_H = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_W = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        D_OH0, D_OH1, D_OW0, D_OW1, D_HS, D_HE, D_WS, D_WE, D_WT
    } t_div_dst;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_CHECK = 17'h00002,
        S_OH0 = 17'h00004,
        S_OH1 = 17'h00008,
        S_OW0 = 17'h00010,
        S_OW1 = 17'h00020,
        S_YCHK = 17'h00040,
        S_HS = 17'h00080,
        S_HE = 17'h00100,
        S_XCHK = 17'h00200,
        S_WS = 17'h00400,
        S_WE = 17'h00800,
        S_AREA = 17'h01000,
        S_WT = 17'h02000,
        S_MUL = 17'h04000,
        S_ACC = 17'h08000,
        S_DONE = 17'h10000
    } t_state;

    typedef struct packed {
        logic     load;
        logic     capture;
        logic     acc_clr;
        logic     div_start;
        t_div_dst div_dst;
        logic     x_init;
        logic     y_inc;
        logic     x_inc;
        logic     area_set;
        logic     mul;
        logic     acc_add;
        logic     emit_res;
        logic     emit_err;
    } t_cmd;

    typedef struct packed {
        logic rng_bad;
        logic y_ok;
        logic x_ok;
        logic div_done;
    } t_sts;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > mx) r = mx;
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/aapb_ram.sv]
`default_nettype none
module aapb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

[hdl/aapb_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module aapb_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [aapb_pkg::DVD_W-1:0] i_dividend,
    input  wire logic [aapb_pkg::DVS_W-1:0] i_divisor,
    output logic                            o_done,
    output logic      [aapb_pkg::DVD_W-1:0] o_quotient
);
    logic [aapb_pkg::CNT_W-1:0] r_cnt;
    logic [aapb_pkg::DVD_W-1:0] r_quo;
    logic [aapb_pkg::DVS_W-1:0] r_rem;
    logic [aapb_pkg::DVS_W-1:0] r_dvs;
    logic                       r_done;
    logic [aapb_pkg::DVS_W:0]   rem_sh;
    logic                       ge;

    assign rem_sh = {r_rem, r_quo[aapb_pkg::DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= aapb_pkg::CNT_W'(aapb_pkg::DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= r_cnt == aapb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? aapb_pkg::DVS_W'(rem_sh - {1'b0, r_dvs})
                        : rem_sh[aapb_pkg::DVS_W-1:0];
            r_quo <= {r_quo[aapb_pkg::DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

[hdl/aapb_dp.sv]
`default_nettype none
module aapb_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire aapb_pkg::t_cmd                 i_cmd,
    output aapb_pkg::t_sts                      o_sts,
    input  wire logic [aapb_pkg::COORD_W-1:0]   i_row,
    input  wire logic [aapb_pkg::COORD_W-1:0]   i_col,
    input  wire logic signed [aapb_pkg::DATA_W-1:0] i_grad_in,
    input  wire logic                           i_cfg_valid,
    input  wire logic [aapb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [aapb_pkg::DIM_W-1:0]     i_cfg_data,
    output logic                                o_result_valid,
    output logic signed [aapb_pkg::DATA_W-1:0]  o_grad_value,
    output logic                                o_range_error
);
    localparam int DW = aapb_pkg::DIM_W;
    localparam int MW = aapb_pkg::MUL_W;

    logic [DW-1:0] r_in_h, r_in_w, r_out_h, r_out_w;
    logic [DW-1:0] ih, iw, oh, ow;
    logic [aapb_pkg::COORD_W-1:0] r_row, r_col;
    logic [DW-1:0] r_y, r_x, r_oh1, r_ow0, r_ow1, r_hs, r_he, r_ws, r_we;
    logic [aapb_pkg::DVS_W-1:0] r_area;
    logic [aapb_pkg::DVD_W-1:0] r_w;
    logic signed [aapb_pkg::PROD_W-1:0] r_prod;
    logic signed [aapb_pkg::ACC_W-1:0]  r_acc;
    logic [aapb_pkg::DVD_W-1:0] dvd, quo;
    logic [aapb_pkg::DVS_W-1:0] dvs;
    logic [MW-1:0] kprod;
    logic [aapb_pkg::DATA_W-1:0] rd_data;
    logic signed [aapb_pkg::ACC_W-1:0] rnd;
    logic signed [aapb_pkg::SH_W-1:0]  sh;
    logic signed [aapb_pkg::DATA_W-1:0] sat;

    assign ih = aapb_pkg::clamp_dim(r_in_h,  DW'(aapb_pkg::MAX_IN_DIM));
    assign iw = aapb_pkg::clamp_dim(r_in_w,  DW'(aapb_pkg::MAX_IN_DIM));
    assign oh = aapb_pkg::clamp_dim(r_out_h, DW'(aapb_pkg::MAX_OUT_DIM));
    assign ow = aapb_pkg::clamp_dim(r_out_w, DW'(aapb_pkg::MAX_OUT_DIM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_h  <= DW'(1);
            r_in_w  <= DW'(1);
            r_out_h <= DW'(1);
            r_out_w <= DW'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aapb_pkg::CFG_IN_H:  r_in_h  <= i_cfg_data;
                aapb_pkg::CFG_IN_W:  r_in_w  <= i_cfg_data;
                aapb_pkg::CFG_OUT_H: r_out_h <= i_cfg_data;
                aapb_pkg::CFG_OUT_W: r_out_w <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window bound operands: floor(i*to/from) and ceil((i+1)*to/from), and the rounded weight 2^24/area
    always_comb begin
        dvd = '0;
        dvs = '0;
        case (i_cmd.div_dst)
            aapb_pkg::D_OH0: begin
                dvd = aapb_pkg::DVD_W'(MW'(r_row) * MW'(oh));
                dvs = aapb_pkg::DVS_W'(ih);
            end
            aapb_pkg::D_OH1: begin
                dvd = aapb_pkg::DVD_W'((MW'(r_row) + 1'b1) * MW'(oh) + MW'(ih) - 1'b1);
                dvs = aapb_pkg::DVS_W'(ih);
            end
            aapb_pkg::D_OW0: begin
                dvd = aapb_pkg::DVD_W'(MW'(r_col) * MW'(ow));
                dvs = aapb_pkg::DVS_W'(iw);
            end
            aapb_pkg::D_OW1: begin
                dvd = aapb_pkg::DVD_W'((MW'(r_col) + 1'b1) * MW'(ow) + MW'(iw) - 1'b1);
                dvs = aapb_pkg::DVS_W'(iw);
            end
            aapb_pkg::D_HS: begin
                dvd = aapb_pkg::DVD_W'(MW'(r_y) * MW'(ih));
                dvs = aapb_pkg::DVS_W'(oh);
            end
            aapb_pkg::D_HE: begin
                dvd = aapb_pkg::DVD_W'((MW'(r_y) + 1'b1) * MW'(ih) + MW'(oh) - 1'b1);
                dvs = aapb_pkg::DVS_W'(oh);
            end
            aapb_pkg::D_WS: begin
                dvd = aapb_pkg::DVD_W'(MW'(r_x) * MW'(iw));
                dvs = aapb_pkg::DVS_W'(ow);
            end
            aapb_pkg::D_WE: begin
                dvd = aapb_pkg::DVD_W'((MW'(r_x) + 1'b1) * MW'(iw) + MW'(ow) - 1'b1);
                dvs = aapb_pkg::DVS_W'(ow);
            end
            aapb_pkg::D_WT: begin
                dvd = aapb_pkg::WEIGHT_ONE + aapb_pkg::DVD_W'(r_area >> 1);
                dvs = r_area;
            end
            default: ;
        endcase
    end

    aapb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (o_sts.div_done),
        .o_quotient (quo)
    );

    aapb_ram #(.WIDTH(aapb_pkg::DATA_W), .DEPTH(aapb_pkg::DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load),
        .i_wr_addr ({i_row, i_col}),
        .i_wr_data (i_grad_in),
        .i_rd_en   (i_cmd.area_set),
        .i_rd_addr ({r_y[aapb_pkg::COORD_W-1:0], r_x[aapb_pkg::COORD_W-1:0]}),
        .o_rd_data (rd_data)
    );

    assign kprod = MW'(r_he - r_hs) * MW'(r_we - r_ws);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (o_sts.div_done) begin
            case (i_cmd.div_dst)
                aapb_pkg::D_OH0: r_y   <= quo[DW-1:0];
                aapb_pkg::D_OH1: r_oh1 <= quo[DW-1:0];
                aapb_pkg::D_OW0: r_ow0 <= quo[DW-1:0];
                aapb_pkg::D_OW1: r_ow1 <= quo[DW-1:0];
                aapb_pkg::D_HS:  r_hs  <= quo[DW-1:0];
                aapb_pkg::D_HE:  r_he  <= quo[DW-1:0];
                aapb_pkg::D_WS:  r_ws  <= quo[DW-1:0];
                aapb_pkg::D_WE:  r_we  <= quo[DW-1:0];
                aapb_pkg::D_WT:  r_w   <= quo;
                default: ;
            endcase
        end
        if (i_cmd.y_inc) r_y <= r_y + 1'b1;
        if (i_cmd.x_init) r_x <= r_ow0;
        else if (i_cmd.x_inc) r_x <= r_x + 1'b1;
        if (i_cmd.area_set) r_area <= aapb_pkg::DVS_W'(kprod);
        if (i_cmd.mul) r_prod <= $signed(rd_data) * $signed({1'b0, r_w});
        if (i_cmd.acc_clr) r_acc <= '0;
        else if (i_cmd.acc_add) r_acc <= r_acc + aapb_pkg::ACC_W'(r_prod);
    end

    // round half up at bit 24, then clamp to 32 bits
    assign rnd = r_acc + (aapb_pkg::ACC_W'(1) <<< 23);
    assign sh  = rnd[aapb_pkg::ACC_W-1:24];
    always_comb begin
        if (sh > aapb_pkg::SH_W'(32'sh7FFF_FFFF)) sat = 32'sh7FFF_FFFF;
        else if (sh < -(aapb_pkg::SH_W'(64'sh8000_0000))) sat = 32'sh8000_0000;
        else sat = sh[aapb_pkg::DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit_res | i_cmd.emit_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_res | i_cmd.emit_err) begin
            o_grad_value  <= i_cmd.emit_err ? '0 : sat;
            o_range_error <= i_cmd.emit_err;
        end
    end

    assign o_sts.rng_bad = (DW'(r_row) >= ih) || (DW'(r_col) >= iw);
    assign o_sts.y_ok    = (r_y < r_oh1) && (r_y < oh);
    assign o_sts.x_ok    = (r_x < r_ow1) && (r_x < ow);
endmodule
`default_nettype wire

[hdl/aapb_ctrl.sv]
`default_nettype none
module aapb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_opcode,
    input  wire aapb_pkg::t_sts i_sts,
    output aapb_pkg::t_cmd      o_cmd,
    output logic                o_busy
);
    aapb_pkg::t_state r_state, n_state;
    logic r_div_start, n_div_start;

    function automatic logic is_div(input aapb_pkg::t_state s);
        return s == aapb_pkg::S_OH0 || s == aapb_pkg::S_OH1 || s == aapb_pkg::S_OW0 ||
               s == aapb_pkg::S_OW1 || s == aapb_pkg::S_HS || s == aapb_pkg::S_HE ||
               s == aapb_pkg::S_WS || s == aapb_pkg::S_WE || s == aapb_pkg::S_WT;
    endfunction

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.div_start = r_div_start;
        o_cmd.div_dst = aapb_pkg::D_WT;
        unique case (r_state)
            aapb_pkg::S_IDLE: begin
                if (i_start && i_rst_n) begin
                    if (i_opcode == aapb_pkg::OP_QUERY) begin
                        o_cmd.capture = 1'b1;
                        n_state = aapb_pkg::S_CHECK;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            aapb_pkg::S_CHECK: begin
                if (i_sts.rng_bad) begin
                    o_cmd.emit_err = 1'b1;
                    n_state = aapb_pkg::S_IDLE;
                end else begin
                    o_cmd.acc_clr = 1'b1;
                    n_state = aapb_pkg::S_OH0;
                end
            end
            aapb_pkg::S_OH0: begin
                o_cmd.div_dst = aapb_pkg::D_OH0;
                if (i_sts.div_done) n_state = aapb_pkg::S_OH1;
            end
            aapb_pkg::S_OH1: begin
                o_cmd.div_dst = aapb_pkg::D_OH1;
                if (i_sts.div_done) n_state = aapb_pkg::S_OW0;
            end
            aapb_pkg::S_OW0: begin
                o_cmd.div_dst = aapb_pkg::D_OW0;
                if (i_sts.div_done) n_state = aapb_pkg::S_OW1;
            end
            aapb_pkg::S_OW1: begin
                o_cmd.div_dst = aapb_pkg::D_OW1;
                if (i_sts.div_done) n_state = aapb_pkg::S_YCHK;
            end
            aapb_pkg::S_YCHK: begin
                n_state = i_sts.y_ok ? aapb_pkg::S_HS : aapb_pkg::S_DONE;
            end
            aapb_pkg::S_HS: begin
                o_cmd.div_dst = aapb_pkg::D_HS;
                if (i_sts.div_done) n_state = aapb_pkg::S_HE;
            end
            aapb_pkg::S_HE: begin
                o_cmd.div_dst = aapb_pkg::D_HE;
                if (i_sts.div_done) begin
                    o_cmd.x_init = 1'b1;
                    n_state = aapb_pkg::S_XCHK;
                end
            end
            aapb_pkg::S_XCHK: begin
                if (i_sts.x_ok) begin
                    n_state = aapb_pkg::S_WS;
                end else begin
                    o_cmd.y_inc = 1'b1;
                    n_state = aapb_pkg::S_YCHK;
                end
            end
            aapb_pkg::S_WS: begin
                o_cmd.div_dst = aapb_pkg::D_WS;
                if (i_sts.div_done) n_state = aapb_pkg::S_WE;
            end
            aapb_pkg::S_WE: begin
                o_cmd.div_dst = aapb_pkg::D_WE;
                if (i_sts.div_done) n_state = aapb_pkg::S_AREA;
            end
            aapb_pkg::S_AREA: begin
                o_cmd.area_set = 1'b1;
                n_state = aapb_pkg::S_WT;
            end
            aapb_pkg::S_WT: begin
                o_cmd.div_dst = aapb_pkg::D_WT;
                if (i_sts.div_done) n_state = aapb_pkg::S_MUL;
            end
            aapb_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = aapb_pkg::S_ACC;
            end
            aapb_pkg::S_ACC: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.x_inc = 1'b1;
                n_state = aapb_pkg::S_XCHK;
            end
            aapb_pkg::S_DONE: begin
                o_cmd.emit_res = 1'b1;
                n_state = aapb_pkg::S_IDLE;
            end
            default: n_state = aapb_pkg::S_IDLE;
        endcase
    end

    // divider kicks off on entry to each divide state
    assign n_div_start = is_div(n_state) && (n_state != r_state);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aapb_pkg::S_IDLE;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
        end
    end

    // no word is taken while in reset
    assign o_busy = !i_rst_n || (r_state != aapb_pkg::S_IDLE);

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> is_div(r_state)) else $error("divide done outside divide state");
    a_start_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !i_sts.div_done) else $error("divide start overlaps done");
    a_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> is_div(r_state)) else $error("divide start outside divide state");
    a_query_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aapb_pkg::S_IDLE && i_start && i_opcode == aapb_pkg::OP_QUERY)
        |=> r_state == aapb_pkg::S_CHECK) else $error("query word not taken");
endmodule
`default_nettype wire

[hdl/adaptive_avg_pool2d_backward_unit.sv]
// Load word: written at the accepting edge, no result, busy stays low.
// Query outside the plane: range check, then error strobe. Query inside: four window
// divides, then two per output row and three plus a multiply-accumulate per cell,
// each divide in the shared bit-serial divider. One query at a time (busy high).
// Strobe lasts one cycle, no stall. Synchronous active-low reset: dimensions read
// back as 1, busy high and cfg ready low while in reset, plane store is not cleared.
`default_nettype none
module adaptive_avg_pool2d_backward_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_opcode,
    input  wire logic [aapb_pkg::COORD_W-1:0]       i_row,
    input  wire logic [aapb_pkg::COORD_W-1:0]       i_col,
    input  wire logic signed [aapb_pkg::DATA_W-1:0] i_grad_in,
    output logic                                    o_result_valid,
    output logic signed [aapb_pkg::DATA_W-1:0]      o_grad_value,
    output logic                                    o_range_error,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [aapb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [aapb_pkg::DIM_W-1:0]         i_cfg_data
);
    aapb_pkg::t_cmd cmd;
    aapb_pkg::t_sts sts;

    assign o_cfg_ready = i_rst_n;

    aapb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    aapb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_grad_in      (i_grad_in),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_grad_value   (o_grad_value),
        .o_range_error  (o_range_error)
    );
endmodule
`default_nettype wire
